@@ design/two_level_page_table_fault_fill_defines.svh @@
// ----------------------------------------------------------------------------
// Page table fill assertion macros
// Shared property wrappers for the controller checks.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_PAGE_TABLE_FAULT_FILL_DEFINES_SVH
`define TWO_LEVEL_PAGE_TABLE_FAULT_FILL_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define TLPT_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define TLPT_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/tlpt_pkg.sv @@
// ----------------------------------------------------------------------------
// Page table fill package
// Constants, entry formats and interface structs shared by all modules.
// ----------------------------------------------------------------------------
package tlpt_pkg;

   localparam int DIR_ENTRIES = 1024;
   localparam int TABLE_SLOTS = 16;
   localparam int IDX_W       = 10;
   localparam int FRAME_W     = 20;
   localparam int ENT_PER_TABLE = 1024;
   localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int STORE_DEPTH = TABLE_SLOTS * ENT_PER_TABLE;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   // The frame's slot comes from a reciprocal multiplication that is exact
   // for every frame number of FRAME_W bits.
   localparam int REC_SHIFT   = FRAME_W + $clog2(TABLE_SLOTS);
   localparam int REC_W       = FRAME_W + 1;
   localparam longint unsigned REC_MULT =
      ((64'd1 << REC_SHIFT) + TABLE_SLOTS - 1) / TABLE_SLOTS;

   localparam logic [31:0] FLAG_PRESENT = 32'h0000_0001;
   localparam logic [31:0] FLAG_RW      = 32'h0000_0002;
   localparam logic [31:0] SHARED_RESET = 32'd4194304;

   localparam logic [2:0] ST_PRESENT      = 3'd0;
   localparam logic [2:0] ST_PAGE_MAPPED  = 3'd1;
   localparam logic [2:0] ST_TABLE_MAPPED = 3'd2;
   localparam logic [2:0] ST_SHARED_BUILT = 3'd3;
   localparam logic [2:0] ST_OUTSIDE      = 3'd4;

   localparam logic REQ_FAULT = 1'b0;
   localparam logic REQ_BUILD = 1'b1;

   localparam logic REG_SHARED_BYTES = 1'b0;

   typedef struct packed {
      logic              present;
      logic [SLOT_W-1:0] slot;
   } dir_entry_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      dir_entry_type    wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } dir_cmd_type;

   typedef struct packed {
      logic                wr_en;
      logic [STORE_AW-1:0] wr_addr;
      logic                wr_data;
      logic                rd_en;
      logic [STORE_AW-1:0] rd_addr;
   } store_cmd_type;

   typedef struct packed {
      logic [2:0]         status;
      logic               table_taken;
      logic               data_taken;
      logic               inv_valid;
      logic [FRAME_W-1:0] inv_page;
      logic [31:0]        entry_written;
   } result_type;

   function automatic logic [31:0] make_entry(input logic [FRAME_W-1:0] frame);
      make_entry = {frame, 12'h000} | FLAG_PRESENT | FLAG_RW;
   endfunction

endpackage

@@ design/tlpt_dir.sv @@
// ----------------------------------------------------------------------------
// Page directory memory
// One-port-write, one-port-read directory of present bits and store slots.
// ----------------------------------------------------------------------------
module tlpt_dir (
   input  logic                   clock,
   input  tlpt_pkg::dir_cmd_type   cmd,
   output tlpt_pkg::dir_entry_type rd_data
);

   tlpt_pkg::dir_entry_type mem [tlpt_pkg::DIR_ENTRIES];
   tlpt_pkg::dir_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/tlpt_store.sv @@
// ----------------------------------------------------------------------------
// Page table store
// Present bits of every page entry of all table slots, one read, one write.
// ----------------------------------------------------------------------------
module tlpt_store (
   input  logic                    clock,
   input  tlpt_pkg::store_cmd_type cmd,
   output logic                    rd_data
);

   logic mem [tlpt_pkg::STORE_DEPTH];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/tlpt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Page table fill sequencer. Clears the directory after reset, then walks
// each item through a frame slot reduction, a directory lookup and a page
// entry check or table sweep; builds outside the shared region skip both.
// ----------------------------------------------------------------------------
`include "two_level_page_table_fault_fill_defines.svh"

module tlpt_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_type,
   input  logic [31:0]                        req_fault_address,
   input  logic [tlpt_pkg::IDX_W-1:0]         req_dir_slot,
   input  logic [tlpt_pkg::FRAME_W-1:0]       req_offered_table_frame,
   input  logic [tlpt_pkg::FRAME_W-1:0]       req_offered_data_frame,
   input  logic [31:0]                        shared_bytes,
   input  logic                               rsp_free,
   output logic                               done,
   output tlpt_pkg::result_type               result,
   output tlpt_pkg::dir_cmd_type              dir_cmd,
   input  tlpt_pkg::dir_entry_type            dir_rd,
   output tlpt_pkg::store_cmd_type            store_cmd,
   input  logic                               store_rd
);

   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_MOD    = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_SWEEP  = 3'd4;
   localparam logic [2:0] S_CHECK  = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;
   localparam logic [2:0] S_REM    = 3'd7;

   localparam logic [tlpt_pkg::IDX_W-1:0] IDX_LAST =
      tlpt_pkg::IDX_W'(tlpt_pkg::ENT_PER_TABLE - 1);
   localparam int PROD_W = tlpt_pkg::FRAME_W + tlpt_pkg::REC_W;
   localparam logic [tlpt_pkg::REC_W-1:0] REC_MULT_C =
      tlpt_pkg::REC_W'(tlpt_pkg::REC_MULT);
   localparam logic [tlpt_pkg::FRAME_W-1:0] SLOTS_C =
      tlpt_pkg::FRAME_W'(tlpt_pkg::TABLE_SLOTS);

   logic [2:0]                            state_ff, state_in;
   logic [tlpt_pkg::IDX_W-1:0]            idx_ff, idx_in;
   logic [tlpt_pkg::FRAME_W-1:0]          quot_ff, quot_in;
   logic [tlpt_pkg::SLOT_W-1:0]           rem_ff, rem_in;
   logic                                  type_ff, type_in;
   logic [31:0]                           addr_ff, addr_in;
   logic [tlpt_pkg::IDX_W-1:0]            dslot_ff, dslot_in;
   logic [tlpt_pkg::FRAME_W-1:0]          tframe_ff, tframe_in;
   logic [tlpt_pkg::FRAME_W-1:0]          dframe_ff, dframe_in;
   logic [tlpt_pkg::FRAME_W:0]            pages_ff, pages_in;
   logic [tlpt_pkg::STORE_AW-1:0]         pte_addr_ff, pte_addr_in;
   tlpt_pkg::result_type                  res_ff, res_in;

   logic                                  accept;
   logic [PROD_W-1:0]                     rec_prod;
   logic [tlpt_pkg::FRAME_W-1:0]          rem_full;
   logic [tlpt_pkg::SLOT_W-1:0]           tslot;
   logic [32:0]                           bytes_sum;
   logic [tlpt_pkg::FRAME_W:0]            pages_calc;
   logic [tlpt_pkg::FRAME_W+1:0]          slots_sum;
   logic [11:0]                           slots_calc;
   logic                                  outside;
   logic [tlpt_pkg::FRAME_W-1:0]          page_no;
   logic [tlpt_pkg::IDX_W-1:0]            pt_idx;
   logic [tlpt_pkg::STORE_AW-1:0]         sweep_addr;
   logic [tlpt_pkg::STORE_AW-1:0]         lookup_addr;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign done      = (state_ff == S_DONE) && rsp_free;
   assign result    = res_ff;

   assign rec_prod   = PROD_W'(tframe_ff) * PROD_W'(REC_MULT_C);
   assign rem_full   = tframe_ff - quot_ff * SLOTS_C;
   assign tslot      = rem_ff;
   assign bytes_sum  = {1'b0, shared_bytes} + 33'd4095;
   assign pages_calc = bytes_sum[32:12];
   assign slots_sum  = {1'b0, pages_calc} + 22'd1023;
   assign slots_calc = slots_sum[21:10];
   assign outside    = ({2'b00, dslot_ff} >= slots_calc);
   assign page_no    = {dslot_ff, idx_ff};
   assign pt_idx     = addr_ff[21:12];
   assign sweep_addr = tlpt_pkg::STORE_AW'({tslot, idx_ff});
   assign lookup_addr = tlpt_pkg::STORE_AW'({dir_rd.slot, pt_idx});

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      quot_in     = quot_ff;
      rem_in      = rem_ff;
      type_in     = type_ff;
      addr_in     = addr_ff;
      dslot_in    = dslot_ff;
      tframe_in   = tframe_ff;
      dframe_in   = dframe_ff;
      pages_in    = pages_ff;
      pte_addr_in = pte_addr_ff;
      res_in      = res_ff;
      dir_cmd     = '0;
      store_cmd   = '0;

      case (state_ff)
         S_INIT: begin
            dir_cmd.wr_en   = 1'b1;
            dir_cmd.wr_addr = idx_ff;
            idx_in          = idx_ff + 1'b1;
            if (idx_ff == IDX_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               type_in         = req_type;
               addr_in         = req_fault_address;
               dslot_in        = req_dir_slot;
               tframe_in       = req_offered_table_frame;
               dframe_in       = req_offered_data_frame;
               res_in          = '0;
               idx_in          = '0;
               dir_cmd.rd_en   = 1'b1;
               dir_cmd.rd_addr = req_fault_address[31:22];
               state_in        = S_MOD;
            end
         end
         S_MOD: begin
            quot_in  = tlpt_pkg::FRAME_W'(rec_prod >> tlpt_pkg::REC_SHIFT);
            state_in = S_REM;
         end
         S_REM: begin
            rem_in   = rem_full[tlpt_pkg::SLOT_W-1:0];
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            pages_in = pages_calc;
            if (type_ff == tlpt_pkg::REQ_BUILD) begin
               if (outside) begin
                  res_in.status = tlpt_pkg::ST_OUTSIDE;
                  state_in      = S_DONE;
               end else begin
                  dir_cmd.wr_en           = 1'b1;
                  dir_cmd.wr_addr         = dslot_ff;
                  dir_cmd.wr_data.present = 1'b1;
                  dir_cmd.wr_data.slot    = tslot;
                  res_in.status           = tlpt_pkg::ST_SHARED_BUILT;
                  res_in.table_taken      = 1'b1;
                  res_in.entry_written    = tlpt_pkg::make_entry(tframe_ff);
                  state_in                = S_SWEEP;
               end
            end else if (!dir_rd.present) begin
               dir_cmd.wr_en           = 1'b1;
               dir_cmd.wr_addr         = addr_ff[31:22];
               dir_cmd.wr_data.present = 1'b1;
               dir_cmd.wr_data.slot    = tslot;
               res_in.status           = tlpt_pkg::ST_TABLE_MAPPED;
               res_in.table_taken      = 1'b1;
               res_in.data_taken       = 1'b1;
               res_in.inv_valid        = 1'b1;
               res_in.inv_page         = addr_ff[31:12];
               res_in.entry_written    = tlpt_pkg::make_entry(dframe_ff);
               state_in                = S_SWEEP;
            end else begin
               store_cmd.rd_en   = 1'b1;
               store_cmd.rd_addr = lookup_addr;
               pte_addr_in       = lookup_addr;
               state_in          = S_CHECK;
            end
         end
         S_SWEEP: begin
            store_cmd.wr_en   = 1'b1;
            store_cmd.wr_addr = sweep_addr;
            if (type_ff == tlpt_pkg::REQ_BUILD) begin
               store_cmd.wr_data = ({1'b0, page_no} < pages_ff);
            end else begin
               store_cmd.wr_data = (idx_ff == pt_idx);
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_LAST) begin
               state_in = S_DONE;
            end
         end
         S_CHECK: begin
            if (!store_rd) begin
               store_cmd.wr_en      = 1'b1;
               store_cmd.wr_addr    = pte_addr_ff;
               store_cmd.wr_data    = 1'b1;
               res_in.status        = tlpt_pkg::ST_PAGE_MAPPED;
               res_in.data_taken    = 1'b1;
               res_in.inv_valid     = 1'b1;
               res_in.inv_page      = addr_ff[31:12];
               res_in.entry_written = tlpt_pkg::make_entry(dframe_ff);
            end else begin
               res_in.status = tlpt_pkg::ST_PRESENT;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
            idx_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      type_ff     <= type_in;
      addr_ff     <= addr_in;
      dslot_ff    <= dslot_in;
      tframe_ff   <= tframe_in;
      dframe_ff   <= dframe_in;
      pages_ff    <= pages_in;
      pte_addr_ff <= pte_addr_in;
      res_ff      <= res_in;
   end

   `TLPT_ASSERT_IMP(a_idle_no_write, state_ff == S_IDLE, !dir_cmd.wr_en && !store_cmd.wr_en, "memory written while idle")
   `TLPT_ASSERT_NXT(a_accept_to_mod, accept, state_ff == S_MOD, "accepted item did not start slot reduction")
   `TLPT_ASSERT_NXT(a_sweep_end, state_ff == S_SWEEP && idx_ff == IDX_LAST, state_ff == S_DONE, "table sweep did not finish")
   `TLPT_ASSERT_IMP(a_inv_matches_data, state_ff == S_DONE, res_ff.inv_valid == res_ff.data_taken, "invalidate without data frame")
   `TLPT_ASSERT_IMP(a_done_free, done, !req_stall == 1'b0, "result issued outside busy phase")

endmodule

@@ design/two_level_page_table_fault_fill.sv @@
// After reset the directory is cleared one entry per cycle; req_stall is high until it is clear.
// A fault item whose directory entry is present runs the slot reduction, the decision and the page
// entry check. A fault item that links a new table, or a build item inside the shared region, ends
// in a table sweep that writes one entry per cycle through the store's single write port. A build
// item outside the shared region goes from the decision to its result. One item is in work at a
// time: after each result the block goes idle and accepts the next while the last result waits.
// ----------------------------------------------------------------------------
// Two-level page table fault fill
// Keeps a page directory and table store, fills faults and builds shared
// identity tables, and reports which offered frames were used.
// ----------------------------------------------------------------------------
module two_level_page_table_fault_fill (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [31:0]                   req_fault_address,
   input  logic [tlpt_pkg::IDX_W-1:0]    req_dir_slot,
   input  logic [tlpt_pkg::FRAME_W-1:0]  req_offered_table_frame,
   input  logic [tlpt_pkg::FRAME_W-1:0]  req_offered_data_frame,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_status,
   output logic                          rsp_table_frame_taken,
   output logic                          rsp_data_frame_taken,
   output logic                          rsp_invalidate_valid,
   output logic [tlpt_pkg::FRAME_W-1:0]  rsp_invalidate_page,
   output logic [31:0]                   rsp_entry_written,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   logic [31:0]              shared_bytes_ff, shared_bytes_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   tlpt_pkg::result_type     rsp_data_ff, rsp_data_in;
   logic                     rsp_free;
   logic                     done;
   tlpt_pkg::result_type     result;
   tlpt_pkg::dir_cmd_type    dir_cmd;
   tlpt_pkg::dir_entry_type  dir_rd;
   tlpt_pkg::store_cmd_type  store_cmd;
   logic                     store_rd;
   logic                     csr_hit;

   assign pready   = 1'b1;
   assign csr_hit  = (paddr[2] == tlpt_pkg::REG_SHARED_BYTES);
   assign prdata   = csr_hit ? shared_bytes_ff : 32'd0;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      shared_bytes_in = shared_bytes_ff;
      if (psel && penable && pwrite && pready && csr_hit) begin
         shared_bytes_in = pwdata;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shared_bytes_ff <= tlpt_pkg::SHARED_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         shared_bytes_ff <= shared_bytes_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_data_ff.status;
   assign rsp_table_frame_taken = rsp_data_ff.table_taken;
   assign rsp_data_frame_taken  = rsp_data_ff.data_taken;
   assign rsp_invalidate_valid  = rsp_data_ff.inv_valid;
   assign rsp_invalidate_page   = rsp_data_ff.inv_page;
   assign rsp_entry_written     = rsp_data_ff.entry_written;

   tlpt_ctrl u_ctrl (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_type                (req_type),
      .req_fault_address       (req_fault_address),
      .req_dir_slot            (req_dir_slot),
      .req_offered_table_frame (req_offered_table_frame),
      .req_offered_data_frame  (req_offered_data_frame),
      .shared_bytes            (shared_bytes_ff),
      .rsp_free                (rsp_free),
      .done                    (done),
      .result                  (result),
      .dir_cmd                 (dir_cmd),
      .dir_rd                  (dir_rd),
      .store_cmd               (store_cmd),
      .store_rd                (store_rd)
   );

   tlpt_dir u_dir (
      .clock   (clock),
      .cmd     (dir_cmd),
      .rd_data (dir_rd)
   );

   tlpt_store u_store (
      .clock   (clock),
      .cmd     (store_cmd),
      .rd_data (store_rd)
   );

endmodule
